// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file csc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, switched off while reset is low
`define CSC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define CSC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// csc_pkg
// Types, widths and helpers for the Clenshaw Chebyshev series pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

  // default highest coefficient index held by the table
  localparam int unsigned MaxDegree = 15;

  // field widths
  localparam int unsigned IdxW    = 4;
  localparam int unsigned IdxMax  = (1 << IdxW) - 1;
  localparam int unsigned DataW   = 32;
  localparam int unsigned SampleW = 16;
  localparam int unsigned ProdW   = DataW + SampleW;
  localparam int unsigned SumW    = DataW + 4;

  // rounding offsets for the two product scalings
  localparam logic signed [ProdW-1:0] StepRnd  = 48'sd8192;
  localparam logic signed [ProdW-1:0] FinalRnd = 48'sd16384;

  // saturation limits
  localparam logic signed [SumW-1:0] SatMax = 36'sd2147483647;
  localparam logic signed [SumW-1:0] SatMin = -36'sd2147483648;

  typedef enum logic {
    ModeLoad = 1'b0,
    ModeEval = 1'b1
  } csc_mode_e;

  // request as it travels down the pipeline, with running recurrence state
  typedef struct packed {
    logic                     vld;
    csc_mode_e                mode;
    logic [IdxW-1:0]          idx;
    logic signed [DataW-1:0]  cval;
    logic signed [SampleW-1:0] y;
    logic signed [DataW-1:0]  q;
    logic signed [DataW-1:0]  r;
    logic                     sat;
  } csc_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] val;
    logic                    sat;
  } csc_clip_t;

  // clamp a wide sum to the signed 32-bit range and flag clipping
  function automatic csc_clip_t csc_clip(input logic signed [SumW-1:0] v);
    csc_clip_t res;
    if (v > SatMax) begin
      res.val = SatMax[DataW-1:0];
      res.sat = 1'b1;
    end else if (v < SatMin) begin
      res.val = SatMin[DataW-1:0];
      res.sat = 1'b1;
    end else begin
      res.val = v[DataW-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/csc_step.sv -----
// ----------------------------------------------------------------------------
// csc_step
// One backward recurrence step for coefficient index K: product stage, then
// add and clip stage. Owns table entry K, written by load requests passing by.
// ----------------------------------------------------------------------------
module csc_step #(
  parameter int unsigned K = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [csc_pkg::IdxW-1:0]     degree_i,
  input  csc_pkg::csc_item_t           item_i,
  output csc_pkg::csc_item_t           item_o
);
  import csc_pkg::*;

  localparam bit              Reachable = (K <= IdxMax);
  localparam logic [IdxW-1:0] IdxK      = IdxW'(K);

  csc_item_t               a_q, b_q;
  csc_item_t               b_d;
  logic signed [ProdW-1:0] prod_q;
  logic signed [DataW-1:0] coef_q;

  logic                    load_hit;
  logic                    active;
  logic signed [DataW-1:0] coef_eff;
  logic signed [ProdW-1:0] prod_rnd;
  logic signed [DataW+1:0] t_w;
  logic signed [SumW-1:0]  sum;
  csc_clip_t               clip;

  // product stage: y * q of the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      prod_q <= '0;
    end else if (en_i) begin
      a_q    <= item_i;
      prod_q <= ProdW'($signed(item_i.y)) * ProdW'($signed(item_i.q));
    end
  end

  // table entry K, updated in request order
  assign load_hit = a_q.vld && (a_q.mode == ModeLoad) && Reachable && (a_q.idx == IdxK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (en_i && load_hit) begin
      coef_q <= a_q.cval;
    end
  end

  // entries above the degree count as zero, keeping q and r at zero
  assign active   = Reachable && (IdxK <= degree_i);
  assign coef_eff = active ? coef_q : '0;

  // p = c[k] + round(2*y*q) - r, clipped
  assign prod_rnd = prod_q + StepRnd;
  assign t_w      = prod_rnd[ProdW-1:14];
  assign sum      = SumW'(coef_eff) + SumW'(t_w) - SumW'(a_q.r);
  assign clip     = csc_clip(sum);

  // recurrence state handed to the next step
  always_comb begin
    b_d     = a_q;
    b_d.q   = clip.val;
    b_d.r   = a_q.q;
    b_d.sat = a_q.sat | clip.sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q <= '0;
    end else if (en_i) begin
      b_q <= b_d;
    end
  end

  assign item_o = b_q;

endmodule

// ----- hw/rtl/csc_final.sv -----
// ----------------------------------------------------------------------------
// csc_final
// Closing step f = q - round(y*r), clipped, and the output register.
// Load requests end here without a result.
// ----------------------------------------------------------------------------
module csc_final (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  csc_pkg::csc_item_t                item_i,
  output logic                              valid_o,
  output logic signed [csc_pkg::DataW-1:0]  value_o,
  output logic                              saturated_o
);
  import csc_pkg::*;

  csc_item_t               a_q;
  logic signed [ProdW-1:0] prod_q;
  logic                    vld_q;
  logic signed [DataW-1:0] value_q;
  logic                    sat_q;

  logic signed [ProdW-1:0] prod_rnd;
  logic signed [DataW:0]   t_w;
  logic signed [SumW-1:0]  diff;
  csc_clip_t               clip;

  // product stage: y * r
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      prod_q <= '0;
    end else if (en_i) begin
      a_q    <= item_i;
      prod_q <= ProdW'($signed(item_i.y)) * ProdW'($signed(item_i.r));
    end
  end

  // subtract and clip
  assign prod_rnd = prod_q + FinalRnd;
  assign t_w      = prod_rnd[ProdW-1:15];
  assign diff     = SumW'(a_q.q) - SumW'(t_w);
  assign clip     = csc_clip(diff);

  // output register, only evaluate requests give a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      value_q <= '0;
      sat_q   <= 1'b0;
    end else if (en_i) begin
      vld_q   <= a_q.vld && (a_q.mode == ModeEval);
      value_q <= clip.val;
      sat_q   <= a_q.sat | clip.sat;
    end
  end

  assign valid_o     = vld_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;

endmodule

// ----- hw/rtl/chebyshev_series_clenshaw_top.sv -----
// ----------------------------------------------------------------------------
// chebyshev_series_clenshaw_top
// Chebyshev series evaluation by the Clenshaw recurrence in fixed point,
// one pipeline step per coefficient index.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o | mode_i, coef_index_i, coef_value_i,
//          |                        | sample_i
//  out     | out_valid_o / out_ready_i | value_o, saturated_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (degree)
//
//  one request enters per cycle unless a result is held; an evaluate
//  result passes the product and add stages of each recurrence step,
//  then the closing step and its output register.
//  reset clears the coefficient table and degree; no clearing pass.
//  the whole pipeline holds while a result waits on out_ready_i.
// ----------------------------------------------------------------------------
module chebyshev_series_clenshaw_top #(
  parameter int unsigned MAX_DEGREE = csc_pkg::MaxDegree
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic [csc_pkg::IdxW-1:0]           coef_index_i,
  input  logic signed [csc_pkg::DataW-1:0]   coef_value_i,
  input  logic signed [csc_pkg::SampleW-1:0] sample_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [csc_pkg::DataW-1:0]   value_o,
  output logic                               saturated_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [csc_pkg::IdxW-1:0]           cfg_data_i
);
  import csc_pkg::*;

  logic            en;
  logic [IdxW-1:0] degree_q;
  csc_item_t       chain [MAX_DEGREE+2];

  // pipeline advances unless a result is held
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign cfg_ready_o = 1'b1;

  // degree register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= '0;
    end else if (cfg_valid_i) begin
      degree_q <= cfg_data_i;
    end
  end

  // request entering the pipeline, recurrence starts from zero
  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = in_valid_i;
    chain[0].mode = csc_mode_e'(mode_i);
    chain[0].idx  = coef_index_i;
    chain[0].cval = coef_value_i;
    chain[0].y    = sample_i;
  end

  // steps for k = MAX_DEGREE down to 0
  for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_step
    csc_step #(
      .K (MAX_DEGREE - g)
    ) u_step (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .degree_i (degree_q),
      .item_i   (chain[g]),
      .item_o   (chain[g+1])
    );
  end

  csc_final u_final (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .item_i      (chain[MAX_DEGREE+1]),
    .valid_o     (out_valid_o),
    .value_o     (value_o),
    .saturated_o (saturated_o)
  );

endmodule

// ----- hw/rtl/csc_checker.sv -----
// ----------------------------------------------------------------------------
// csc_checker
// Port-level checks on the series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_o,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic signed [csc_pkg::DataW-1:0]   value_o,
  input logic                               saturated_o
);
  import csc_pkg::*;

  logic           out_stall;
  logic [DataW:0] result_bits;

  // result waiting on the receiver
  assign out_stall   = out_valid_o && !out_ready_i;
  assign result_bits = {value_o, saturated_o};

  // a result offered stays offered until taken
  `CSC_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o, "result dropped")

  // a stalled result keeps its payload
  `CSC_ASSERT(a_out_stable, clk_i, rst_ni, out_stall |=> $stable(result_bits), "result changed")

  // a held result blocks new requests
  `CSC_ASSERT_NEVER(a_stall_blocks_in, clk_i, rst_ni, out_stall && in_ready_o, "input open")

  // with no result pending the input is open
  `CSC_ASSERT_NEVER(a_idle_ready, clk_i, rst_ni, !out_valid_o && !in_ready_o, "input blocked")

endmodule

bind chebyshev_series_clenshaw_top csc_checker u_csc_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Regression for the Clenshaw Chebyshev series block. A local fixed-point
// predictor follows every accepted request (coefficient loads and series
// evaluations) and queues the expected results. A checking process compares
// each result with the oldest one queued. Stimulus is a short directed set
// followed by random phases, each at its own degree setting. Input gaps come
// in bursts, output stalls follow their own pattern, and one long stall fills
// the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import csc_pkg::*;

  localparam int unsigned TableDepth   = MaxDegree + 1;
  localparam int          DrainCycles  = 2 * (MaxDegree + 1) + 2 + 16;
  localparam int          HoldCycles   = 300;
  localparam int          IdleLimit    = 4000;
  localparam int          ReportLimit  = 10;
  localparam longint      Q16Max       = 64'sd2147483647;
  localparam longint      Q16Min       = -64'sd2147483648;
  localparam longint      StepRound    = 64'sd8192;
  localparam longint      FinalRound   = 64'sd16384;

  typedef struct {
    csc_mode_e                 mode;
    logic [IdxW-1:0]           idx;
    logic signed [DataW-1:0]   cval;
    logic signed [SampleW-1:0] y;
  } series_req_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    sat;
  } series_res_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      mode_i;
  logic [IdxW-1:0]           coef_index_i;
  logic signed [DataW-1:0]   coef_value_i;
  logic signed [SampleW-1:0] sample_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [DataW-1:0]   value_o;
  logic                      saturated_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [IdxW-1:0]           cfg_data_i;

  // predictor state
  logic signed [DataW-1:0] coef_tab [TableDepth];
  logic [IdxW-1:0]         degree_reg;
  series_res_t             expected_q [$];

  int error_count  = 0;
  int burst_left   = 0;
  bit sender_bursty = 1'b1;
  int hold_asked   = 0;

  chebyshev_series_clenshaw_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_o      (value_o),
    .saturated_o  (saturated_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // clamp to signed 32 bits, noting any clipping
  function automatic longint clamp_q16(input longint v, inout bit clipped);
    if (v > Q16Max) begin
      clipped = 1'b1;
      return Q16Max;
    end
    if (v < Q16Min) begin
      clipped = 1'b1;
      return Q16Min;
    end
    return v;
  endfunction

  // backward recurrence over the table at the current degree
  function automatic series_res_t clenshaw_eval(input logic signed [SampleW-1:0] y);
    longint      yl;
    longint      q;
    longint      r;
    longint      p;
    longint      t;
    bit          clipped;
    int          k;
    series_res_t res;
    clipped = 1'b0;
    yl = y;
    q  = coef_tab[degree_reg];
    r  = 0;
    for (k = int'(degree_reg); k > 0; k--) begin
      t = (yl * q + StepRound) >>> 14;
      p = clamp_q16(longint'(coef_tab[k-1]) + t - r, clipped);
      r = q;
      q = p;
    end
    t = (yl * r + FinalRound) >>> 15;
    q = clamp_q16(q - t, clipped);
    res.value = q[DataW-1:0];
    res.sat   = clipped;
    return res;
  endfunction

  // update the table or queue the series value for one accepted request
  function automatic void apply_request(input series_req_t req);
    if (req.mode == ModeLoad) begin
      coef_tab[req.idx] = req.cval;
    end else begin
      expected_q.push_back(clenshaw_eval(req.y));
    end
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    case ($urandom_range(0, 19))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SampleW'($urandom());
    endcase
  endfunction

  // random request; wide_pct sets how often a coefficient spans the full range
  function automatic series_req_t random_request(input int eval_pct, input int wide_pct);
    series_req_t req;
    req.mode = ($urandom_range(0, 99) < eval_pct) ? ModeEval : ModeLoad;
    req.idx  = IdxW'($urandom());
    req.y    = random_sample();
    if ($urandom_range(0, 99) < wide_pct) begin
      case ($urandom_range(0, 5))
        0: req.cval = 32'sh7fffffff;
        1: req.cval = 32'sh80000000;
        default: req.cval = $urandom();
      endcase
    end else begin
      req.cval = int'($urandom_range(0, 524288)) - 262144;
    end
    return req;
  endfunction

  // send one request, with burst gaps, and predict once accepted
  task automatic send_item(input series_req_t req);
    if (sender_bursty && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 60);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= req.mode;
    coef_index_i <= req.idx;
    coef_value_i <= req.cval;
    sample_i     <= req.y;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    apply_request(req);
  endtask

  task automatic send_load(input logic [IdxW-1:0] idx, input logic signed [DataW-1:0] val);
    series_req_t req;
    req.mode = ModeLoad;
    req.idx  = idx;
    req.cval = val;
    req.y    = SampleW'($urandom());
    send_item(req);
  endtask

  task automatic send_eval(input logic signed [SampleW-1:0] y);
    series_req_t req;
    req.mode = ModeEval;
    req.idx  = IdxW'($urandom());
    req.cval = $urandom();
    req.y    = y;
    send_item(req);
  endtask

  // stop sending, collect every result and let loads in flight settle
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_degree(input logic [IdxW-1:0] deg);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= deg;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    degree_reg = deg;
  endtask

  task automatic log_failure(input string msg);
    error_count++;
    if (error_count <= ReportLimit) $display("%s", msg);
  endtask

  // ---- tests ----

  // the table reads zero after reset, at both degree extremes
  task automatic test_cleared_table();
    send_eval(16'sh7fff);
    write_degree(4'd15);
    send_eval(16'sh8000);
  endtask

  // degree zero returns c[0] unchanged, even at the range limits
  task automatic test_degree_zero();
    write_degree(4'd0);
    send_load(4'd0, 32'sh7fffffff);
    send_eval(16'sh8000);
    send_load(4'd0, 32'sh80000000);
    send_eval(16'sh7fff);
  endtask

  // top table entry and sample extremes at full degree
  task automatic test_top_index();
    write_degree(4'd15);
    send_load(4'd15, 32'sh7fffffff);
    send_load(4'd14, 32'sh80000000);
    send_eval(16'sh7fff);
    send_eval(16'sh8000);
    send_eval(16'sh0000);
    send_eval(16'shffff);
  endtask

  // large neighbouring coefficients push the recurrence into clipping
  task automatic test_saturation();
    send_load(4'd14, 32'sh7fffffff);
    send_eval(16'sh7fff);
    send_eval(16'sh8000);
  endtask

  task automatic run_phase(input logic [IdxW-1:0] deg, input int count, input int wide_pct);
    write_degree(deg);
    repeat (count) send_item(random_request(50, wide_pct));
  endtask

  // random loads and evaluations across several degree settings
  task automatic test_random_series();
    run_phase(4'd15, 150, 5);
    run_phase(4'd0, 120, 30);
    run_phase(4'd7, 200, 30);
    run_phase(4'd1, 150, 20);
    run_phase(IdxW'($urandom_range(2, 14)), 180, 10);
    run_phase(4'd15, 200, 50);
  endtask

  // long output stall while requests keep coming, so the input backs up
  task automatic test_fill_and_stall();
    write_degree(4'd15);
    sender_bursty = 1'b0;
    hold_asked++;
    repeat (120) send_item(random_request(80, 10));
    sender_bursty = 1'b1;
  endtask

  // output stall pattern, plus the long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  logic [9:0] stall_phase = '0;
  always @(posedge clk_i) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HoldCycles;
    end
    stall_phase <= stall_phase + 10'd1;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (stall_phase[9:8])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready_i <= (stall_phase[1:0] != 2'd0);
        default: out_ready_i <= $urandom_range(0, 1);
      endcase
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    series_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected result: value %0d saturated %0b",
                              value_o, saturated_o));
      end else begin
        want = expected_q.pop_front();
        if (want.value !== value_o || want.sat !== saturated_o) begin
          log_failure($sformatf("mismatch: value exp %0d got %0d, saturated exp %0b got %0b",
                                want.value, value_o, want.sat, saturated_o));
        end
      end
    end
  end

  // watchdog on cycles with no request moving anywhere
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("chebyshev_series_clenshaw_top regression: fail");
        $finish;
      end
    end
  end

  // sequence
  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= ModeLoad;
    coef_index_i <= '0;
    coef_value_i <= '0;
    sample_i     <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_data_i   <= '0;
    out_ready_i  <= 1'b0;
    for (int i = 0; i < TableDepth; i++) coef_tab[i] = '0;
    degree_reg = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cleared_table();
    test_degree_zero();
    test_top_index();
    test_saturation();
    test_random_series();
    test_fill_and_stall();

    drain_pipeline();
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("chebyshev_series_clenshaw_top regression: pass");
    end else begin
      $display("chebyshev_series_clenshaw_top regression: fail");
    end
    $finish;
  end

endmodule
